// ----- rtl/tmwf_pkg.sv -----
// Package for the trimmed-mean window filter.
// Holds default sizes, the command control struct and the back-end state type.
// No dependencies.
package tmwf_pkg;

   // Default sizes of the filter.
   localparam int DEF_WINDOW_LEN    = 20;
   localparam int DEF_TRIM_EACH_END = 4;
   localparam int DEF_SAMPLE_BITS   = 16;

   // Depth of the command queue between front and back.
   localparam int CMD_QUEUE_DEPTH = 2;

   // Control half of a command word passed from the front to the back.
   typedef struct packed {
      logic do_write;
      logic do_compute;
   } cmd_ctrl_type;

   // Back-end sequencer states.
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_RANK,
      BK_SUM,
      BK_DIV,
      BK_DONE
   } back_state_type;

endpackage

// ----- rtl/tmwf_front.sv -----
// Front end of the trimmed-mean window filter: takes sample words and turns them
// into window-write and compute commands.
// Depends on tmwf_pkg.
module tmwf_front
   import tmwf_pkg::*;
#(
   parameter int WINDOW_LEN  = DEF_WINDOW_LEN,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_sample_present,
   input  logic                          cmd_full,
   output logic                          cmd_push,
   output cmd_ctrl_type                  cmd_ctrl,
   output logic [$clog2(WINDOW_LEN)-1:0] cmd_slot,
   output logic [SAMPLE_BITS-1:0]        cmd_sample
);

   localparam int IDX_BITS = $clog2(WINDOW_LEN);

   logic [IDX_BITS-1:0] write_slot_ff, write_slot_in;
   logic [IDX_BITS-1:0] tick_phase_ff, tick_phase_in;
   logic                accept;
   logic                phase_last;
   logic                slot_last;

   // A word is taken whenever the queue has room.
   assign req_full   = cmd_full;
   assign accept     = req_push && !cmd_full;
   assign phase_last = (tick_phase_ff == IDX_BITS'(WINDOW_LEN - 1));
   assign slot_last  = (write_slot_ff == IDX_BITS'(WINDOW_LEN - 1));

   // Classify the word: a present sample writes, the last tick of a period computes.
   assign cmd_ctrl.do_write   = req_sample_present;
   assign cmd_ctrl.do_compute = phase_last;
   assign cmd_push   = accept && (req_sample_present || phase_last);
   assign cmd_slot   = write_slot_ff;
   assign cmd_sample = req_sample;

   // Next values of the slot pointer and tick counter.
   always_comb begin
      write_slot_in = write_slot_ff;
      tick_phase_in = tick_phase_ff;
      if (accept) begin
         if (req_sample_present) begin
            write_slot_in = slot_last ? '0 : write_slot_ff + 1'b1;
         end
         tick_phase_in = phase_last ? '0 : tick_phase_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_slot_ff <= '0;
         tick_phase_ff <= '0;
      end else begin
         write_slot_ff <= write_slot_in;
         tick_phase_ff <= tick_phase_in;
      end
   end

endmodule

// ----- rtl/tmwf_cmd_queue.sv -----
// Short command queue between the front and back ends of the filter.
// Depends on tmwf_pkg.
module tmwf_cmd_queue
   import tmwf_pkg::*;
#(
   parameter int DATA_BITS = 21
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  cmd_ctrl_type         push_ctrl,
   input  logic [DATA_BITS-1:0] push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 empty,
   output cmd_ctrl_type         pop_ctrl,
   output logic [DATA_BITS-1:0] pop_data
);

   localparam int PTR_BITS = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(CMD_QUEUE_DEPTH + 1);

   cmd_ctrl_type         ctrl_ff [CMD_QUEUE_DEPTH];
   logic [DATA_BITS-1:0] data_ff [CMD_QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full     = (count_ff == CNT_BITS'(CMD_QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_ctrl = ctrl_ff[rd_ptr_ff];
   assign pop_data = data_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         ctrl_ff[wr_ptr_ff] <= push_ctrl;
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/tmwf_back.sv -----
// Back end of the trimmed-mean window filter: holds the window, ranks it, sums
// the middle values and divides by their count, then loads the result register.
// Depends on tmwf_pkg.
module tmwf_back
   import tmwf_pkg::*;
#(
   parameter int WINDOW_LEN    = DEF_WINDOW_LEN,
   parameter int TRIM_EACH_END = DEF_TRIM_EACH_END,
   parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_empty,
   output logic                          cmd_pop,
   input  cmd_ctrl_type                  cmd_ctrl,
   input  logic [$clog2(WINDOW_LEN)-1:0] cmd_slot,
   input  logic [SAMPLE_BITS-1:0]        cmd_sample,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic signed [SAMPLE_BITS-1:0] rsp_trimmed_mean
);

   localparam int IDX_BITS    = $clog2(WINDOW_LEN);
   localparam int MID_COUNT   = WINDOW_LEN - 2 * TRIM_EACH_END;
   localparam int DIVISOR     = (MID_COUNT > 0) ? MID_COUNT : 1;
   localparam int SUM_BITS    = SAMPLE_BITS + $clog2(WINDOW_LEN + 1);
   localparam int MAG_BITS    = SUM_BITS + 1;
   // Reciprocal of the divisor, scaled so that the truncated product gives the
   // exact quotient for every dividend of MAG_BITS bits.
   localparam int RECIP_SHIFT = MAG_BITS + $clog2(DIVISOR);
   localparam logic [MAG_BITS:0] RECIP = (MAG_BITS + 1)'(
      ((64'd1 << RECIP_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

   back_state_type state_ff, state_in;

   logic signed [SAMPLE_BITS-1:0] window_ff [WINDOW_LEN];
   logic [IDX_BITS-1:0]           rank_ff   [WINDOW_LEN];
   logic [IDX_BITS-1:0]           rank_in   [WINDOW_LEN];
   logic [IDX_BITS-1:0]           idx_ff, idx_in;
   logic signed [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [MAG_BITS-1:0]           dq_ff, dq_in;
   logic                          step_ff, step_in;
   logic                          out_valid_ff, out_valid_in;
   logic [SAMPLE_BITS-1:0]        out_ff, out_in;

   logic signed [SAMPLE_BITS-1:0] probe;
   logic                          idx_last;
   logic                          in_middle;
   logic [SUM_BITS-1:0]           sum_abs;
   logic [MAG_BITS-1:0]           mag;
   logic [2*MAG_BITS:0]           prod;
   logic [SAMPLE_BITS-1:0]        quot_next;
   logic [SAMPLE_BITS-1:0]        quot;
   logic [SAMPLE_BITS-1:0]        result;

   // The streamed entry that all rank lanes compare against in this cycle.
   assign probe     = window_ff[idx_ff];
   assign idx_last  = (idx_ff == IDX_BITS'(WINDOW_LEN - 1));
   assign in_middle = (32'(rank_ff[idx_ff]) >= TRIM_EACH_END)
                   && (32'(rank_ff[idx_ff]) < WINDOW_LEN - TRIM_EACH_END);

   // Rounded magnitude to divide: |sum| plus half the divisor.
   assign sum_abs = sum_ff[SUM_BITS-1] ? (~sum_ff + 1'b1) : sum_ff;
   assign mag     = {1'b0, sum_abs} + MAG_BITS'(DIVISOR / 2);

   // Division by the constant count as a multiply by its scaled reciprocal.
   assign prod      = dq_ff * RECIP;
   assign quot_next = prod[RECIP_SHIFT +: SAMPLE_BITS];

   // Sign is restored on the quotient; the mean always fits the sample width.
   assign quot   = dq_ff[SAMPLE_BITS-1:0];
   assign result = sum_ff[SUM_BITS-1] ? (~quot + 1'b1) : quot;

   assign rsp_empty        = !out_valid_ff;
   assign rsp_trimmed_mean = out_ff;

   // Rank lanes: each lane counts the entries that order before its own entry,
   // with ties broken by slot index so that every rank is distinct.
   always_comb begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
         rank_in[i] = rank_ff[i];
         if (state_ff == BK_IDLE) begin
            rank_in[i] = '0;
         end else if (state_ff == BK_RANK) begin
            if ((probe < window_ff[i])
                  || ((probe == window_ff[i]) && (idx_ff < IDX_BITS'(i)))) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end
      end
   end

   // Sequencer: next state and datapath controls.
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      dq_in        = dq_ff;
      step_in      = step_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      cmd_pop      = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            idx_in = '0;
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               if (cmd_ctrl.do_compute) begin
                  state_in = BK_RANK;
               end
            end
         end
         BK_RANK: begin
            if (idx_last) begin
               idx_in   = '0;
               sum_in   = '0;
               state_in = BK_SUM;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         BK_SUM: begin
            if (in_middle) begin
               sum_in = sum_ff + SUM_BITS'(probe);
            end
            if (idx_last) begin
               state_in = BK_DIV;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
            dq_in   = '0;
            step_in = 1'b0;
         end
         BK_DIV: begin
            if (!step_ff) begin
               // Register the rounded dividend before the multiply.
               dq_in   = mag;
               step_in = 1'b1;
            end else begin
               dq_in    = {{(MAG_BITS - SAMPLE_BITS){1'b0}}, quot_next};
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            // Wait for the result register to be free.
            if (!out_valid_ff || rsp_pop) begin
               out_in       = result;
               out_valid_in = 1'b1;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      sum_ff  <= sum_in;
      dq_ff   <= dq_in;
      step_ff <= step_in;
      out_ff  <= out_in;
      rank_ff <= rank_in;
   end

   // Window store: cleared at reset, written from the command queue.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_LEN; i++) begin
            window_ff[i] <= '0;
         end
      end else if (cmd_pop && cmd_ctrl.do_write) begin
         window_ff[cmd_slot] <= cmd_sample;
      end
   end

endmodule

// ----- rtl/trimmed_mean_window_filter_top.sv -----
// Trimmed-mean window filter, top level.
// Request words go in through push/full, results leave through empty/pop.
// Each request word is one sample tick with a sample and a present flag.
// A present sample overwrites the oldest slot of a ring window cleared at reset.
// On every WINDOW_LEN-th tick the window is ranked, TRIM_EACH_END values are
// dropped at each end and the rounded mean of the rest is queued as a result.
// Ticks that do not compute are taken one per cycle while the command queue
// has room; a computing tick occupies the back end while it takes the
// command, makes a rank pass and a sum pass over the window, registers the
// rounded dividend, divides it by reciprocal multiply and loads the result
// register.
// Full rises when the two-entry command queue fills; while a result waits for
// pop, the back end holds the next result, and ticks keep flowing until the
// queue is full. Reset empties the queue and the result register, clears the
// window, the write slot and the tick counter.
// Depends on tmwf_pkg, tmwf_front, tmwf_cmd_queue and tmwf_back.
module trimmed_mean_window_filter_top
   import tmwf_pkg::*;
#(
   parameter int WINDOW_LEN    = DEF_WINDOW_LEN,
   parameter int TRIM_EACH_END = DEF_TRIM_EACH_END,
   parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_sample_present,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic signed [SAMPLE_BITS-1:0] rsp_trimmed_mean
);

   localparam int IDX_BITS  = $clog2(WINDOW_LEN);
   localparam int DATA_BITS = IDX_BITS + SAMPLE_BITS;

   logic                   fe_push;
   cmd_ctrl_type           fe_ctrl;
   logic [IDX_BITS-1:0]    fe_slot;
   logic [SAMPLE_BITS-1:0] fe_sample;
   logic                   q_full;
   logic                   q_empty;
   logic                   q_pop;
   cmd_ctrl_type           q_ctrl;
   logic [DATA_BITS-1:0]   q_data;

   // Front end: tick counting and command generation.
   tmwf_front #(
      .WINDOW_LEN  (WINDOW_LEN),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_sample         (req_sample),
      .req_sample_present (req_sample_present),
      .cmd_full           (q_full),
      .cmd_push           (fe_push),
      .cmd_ctrl           (fe_ctrl),
      .cmd_slot           (fe_slot),
      .cmd_sample         (fe_sample)
   );

   // Command queue decoupling the two ends.
   tmwf_cmd_queue #(
      .DATA_BITS (DATA_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fe_push),
      .push_ctrl (fe_ctrl),
      .push_data ({fe_slot, fe_sample}),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_ctrl  (q_ctrl),
      .pop_data  (q_data)
   );

   // Back end: window store, ranking, summing and division.
   tmwf_back #(
      .WINDOW_LEN    (WINDOW_LEN),
      .TRIM_EACH_END (TRIM_EACH_END),
      .SAMPLE_BITS   (SAMPLE_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_empty        (q_empty),
      .cmd_pop          (q_pop),
      .cmd_ctrl         (q_ctrl),
      .cmd_slot         (q_data[DATA_BITS-1:SAMPLE_BITS]),
      .cmd_sample       (q_data[SAMPLE_BITS-1:0]),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_trimmed_mean (rsp_trimmed_mean)
   );

endmodule

// ----- test/tb_trimmed_mean_window_filter_top.sv -----
// Testbench for the trimmed-mean window filter top level, default sizes.
// Drives sample ticks through the push/full side and checks every popped
// trimmed mean against a model of the window. Depends on tmwf_pkg and the top level.
`timescale 1ns / 100ps

module tb_trimmed_mean_window_filter_top
   import tmwf_pkg::*;
();

   localparam int WIN_LEN     = DEF_WINDOW_LEN;
   localparam int TRIM_END    = DEF_TRIM_EACH_END;
   localparam int SMP_BITS    = DEF_SAMPLE_BITS;
   localparam int HOLD_CYCLES = 1000;
   localparam int DRAIN_WAIT  = 150;
   localparam int STALL_LIMIT = 4000;

   typedef logic signed [SMP_BITS-1:0] sample_type;

   // Content styles for one window's worth of ticks.
   typedef enum int {
      MODE_FULL,
      MODE_EXTREME,
      MODE_NEAR_ZERO,
      MODE_CLUSTER,
      MODE_SPARSE
   } window_mode_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   sample_type req_sample = '0;
   logic       req_sample_present = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   sample_type rsp_trimmed_mean;

   // Model of the filter state, updated on every accepted tick.
   sample_type window_copy [WIN_LEN];
   int         next_slot = 0;
   int         tick_count = 0;
   sample_type expected_means [$];

   int   error_count = 0;
   int   stall_cycles = 0;
   bit   sender_idle = 1'b1;
   bit   receiver_idle = 1'b1;
   int   hold_requests = 0;
   int   hold_served = 0;
   int   hold_left = 0;
   sample_type cluster_base = '0;

   trimmed_mean_window_filter_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_sample         (req_sample),
      .req_sample_present (req_sample_present),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_trimmed_mean   (rsp_trimmed_mean)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Rank the window, drop both ends and round the mean half away from zero.
   function automatic sample_type window_trimmed_mean();
      sample_type ranked [WIN_LEN];
      sample_type key;
      int         j;
      int         middle;
      longint     total;
      longint     mag;
      longint     quot;
      middle = WIN_LEN - 2 * TRIM_END;
      total = 0;
      if (middle <= 0) begin
         return '0;
      end
      for (int i = 0; i < WIN_LEN; i++) begin
         key = window_copy[i];
         j = i;
         while (j > 0 && ranked[j-1] > key) begin
            ranked[j] = ranked[j-1];
            j--;
         end
         ranked[j] = key;
      end
      for (int i = TRIM_END; i < WIN_LEN - TRIM_END; i++) begin
         total += longint'(ranked[i]);
      end
      mag = (total < 0) ? -total : total;
      quot = (mag + middle / 2) / middle;
      return sample_type'((total < 0) ? -quot : quot);
   endfunction

   // Apply one accepted tick to the model and queue a mean on every full turn.
   function automatic void note_tick(sample_type value, logic present);
      if (present) begin
         window_copy[next_slot] = value;
         next_slot = (next_slot + 1) % WIN_LEN;
      end
      tick_count = (tick_count + 1) % WIN_LEN;
      if (tick_count == 0) begin
         expected_means.push_back(window_trimmed_mean());
      end
   endfunction

   // Offer one tick word and hold it until the block takes it.
   task automatic offer_tick(input sample_type value, input logic present);
      while (sender_idle && $urandom_range(0, 99) < 7) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push           <= 1'b1;
      req_sample         <= value;
      req_sample_present <= present;
      do begin
         @(posedge clock);
      end while (req_full);
      note_tick(value, present);
   endtask

   function automatic sample_type pick_extreme();
      case ($urandom_range(0, 3))
         0:       return sample_type'(16'sh7FFF);
         1:       return sample_type'(16'sh8000);
         2:       return sample_type'(16'sh7FFE);
         default: return sample_type'(16'sh8001);
      endcase
   endfunction

   // Send a whole window's worth of ticks in the given style.
   task automatic send_window(input window_mode_type mode);
      sample_type value;
      logic       present;
      cluster_base = sample_type'($urandom_range(0, 65535));
      for (int k = 0; k < WIN_LEN; k++) begin
         present = ($urandom_range(0, 99) < 92);
         case (mode)
            MODE_EXTREME: value = pick_extreme();
            MODE_NEAR_ZERO: value = sample_type'(int'($urandom_range(0, 15)) - 8);
            MODE_CLUSTER: begin
               if ($urandom_range(0, 99) < 20) begin
                  value = pick_extreme();
               end else begin
                  value = cluster_base + sample_type'(int'($urandom_range(0, 63)) - 32);
               end
            end
            MODE_SPARSE: begin
               value = sample_type'($urandom_range(0, 65535));
               present = ($urandom_range(0, 99) < 30);
            end
            default: value = sample_type'($urandom_range(0, 65535));
         endcase
         offer_tick(value, present);
      end
   endtask

   // A short run of random ticks that shifts the window boundary.
   task automatic send_noise_burst();
      int len;
      len = $urandom_range(1, WIN_LEN - 1);
      repeat (len) begin
         offer_tick(sample_type'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
      end
   endtask

   // First window after reset: field extremes, absent ticks, and five slots
   // left at their reset value of zero so they join the ranking.
   task automatic test_first_window_extremes();
      offer_tick(16'sh7FFF, 1'b1);
      offer_tick(16'sh8000, 1'b1);
      offer_tick(16'sh0000, 1'b1);
      offer_tick(-16'sd1, 1'b1);
      offer_tick(16'sd1, 1'b1);
      offer_tick(16'sh5555, 1'b1);
      offer_tick(16'shAAAA, 1'b1);
      offer_tick(16'sh7FFF, 1'b0);
      offer_tick(16'sh8000, 1'b0);
      offer_tick(16'sd256, 1'b1);
      offer_tick(-16'sd256, 1'b1);
      offer_tick(16'sh7FFF, 1'b1);
      offer_tick(16'sh8000, 1'b1);
      offer_tick(16'sd127, 1'b0);
      offer_tick(16'sd12345, 1'b1);
      offer_tick(-16'sd12345, 1'b1);
      offer_tick(16'sh7FFE, 1'b1);
      offer_tick(16'sh8001, 1'b1);
      offer_tick(16'sh0000, 1'b0);
      offer_tick(16'shFFFF, 1'b0);
   endtask

   // Mostly aligned windows of random styles, with the odd misaligning burst.
   task automatic test_random_windows(input int windows);
      for (int w = 0; w < windows; w++) begin
         if ($urandom_range(0, 99) < 15) begin
            send_noise_burst();
         end
         send_window(window_mode_type'($urandom_range(0, 4)));
      end
   endtask

   // Back-to-back words on both sides with no idling at all.
   task automatic test_steady_stream(input int windows);
      sender_idle   = 1'b0;
      receiver_idle = 1'b0;
      test_random_windows(windows);
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
   endtask

   // The receiver stops popping for a long stretch while ticks keep coming,
   // so the result side backs up and full must rise.
   task automatic test_result_backpressure(input int windows);
      sender_idle = 1'b0;
      hold_requests++;
      test_random_windows(windows);
      sender_idle = 1'b1;
   endtask

   // Result checker and receiver pacing.
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_means.size() == 0) begin
            if (error_count < 10) begin
               $display("unexpected word: got %0d", rsp_trimmed_mean);
            end
            error_count++;
         end else begin
            if (rsp_trimmed_mean !== expected_means[0]) begin
               if (error_count < 10) begin
                  $display("mismatch on trimmed_mean: expected %0d, got %0d",
                           expected_means[0], rsp_trimmed_mean);
               end
               error_count++;
            end
            void'(expected_means.pop_front());
         end
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served++;
         hold_left = HOLD_CYCLES;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= !(receiver_idle && $urandom_range(0, 99) < 7);
      end
   end

   // Watchdog: ends the run if no word moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no word accepted for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      for (int i = 0; i < WIN_LEN; i++) begin
         window_copy[i] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_first_window_extremes();
      test_random_windows(25);
      test_steady_stream(15);
      test_result_backpressure(10);
      test_random_windows(12);

      req_push <= 1'b0;
      while (expected_means.size() != 0) begin
         @(posedge clock);
      end
      // Give a late, unexpected word time to show up.
      repeat (DRAIN_WAIT) @(posedge clock);
      if (expected_means.size() != 0) begin
         error_count++;
      end
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
